FILE: hw/rtl/command_line_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Assert that prop holds at every rising clock edge outside reset.
`define CLT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that ante implies cons in the next cycle.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/clt_pkg.sv
// Types and constants of the command line tokenizer.
`default_nettype none

package clt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } mode_e;

  typedef enum logic {
    REG_MAX_TOKENS     = 1'b0,
    REG_TOKEN_CAPACITY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    logic [7:0] token_index;
    logic [7:0] token_count;
    logic       last;
  } out_item_t;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [QueuePtrW-1:0] ptr_t;
  typedef logic [QueueCntW-1:0] cnt_t;

  localparam cnt_t StallLevel = cnt_t'(QueueDepth - MaxResults);

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharSquote    = 8'h27;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharSpace     = 8'h20;

  localparam logic [6:0] CapArray        = 7'd64;
  localparam logic [7:0] MaxTokensReset  = 8'd16;
  localparam logic [6:0] CapacityReset   = 7'd64;

endpackage

`default_nettype wire

FILE: hw/rtl/command_line_tokenizer.sv
// Command line tokenizer: splits a byte stream into tokens with quotes and escapes.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+--------------------------------
//   in      | in  | in_valid_i / in_stall_o   | in_data_i  (char_code, end_of_line)
//   out     | out | out_valid_o / out_stall_i | out_data_o (kind, out_char,
//           |     |                           |   token_index, token_count, last)
//   cfg     | in  | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item is accepted per cycle while in_stall_o is low; its results land in a four-entry
// queue in the same edge. The queue drains one result per cycle while out_stall_i is low, and
// an item gives up to three results; in_stall_o rises while more than one result is queued.
// Reset empties the queue, clears the line state and loads max_tokens 16, capacity 64.
// A stalled output holds its item; input keeps flowing while the queue has room.
`default_nettype none

module command_line_tokenizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire clt_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output clt_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  logic [7:0]      max_tok_q;
  logic [6:0]      cap_q;

  clt_pkg::mode_e  mode_q, mode_d;
  logic            qs_q, qs_d;
  logic            esc_q, esc_d;
  logic [5:0]      chars_q, chars_d;
  logic [7:0]      tok_q, tok_d;

  clt_pkg::out_item_t res [clt_pkg::MaxResults];
  logic [1:0]      n_res;

  clt_pkg::out_item_t mem_q [clt_pkg::QueueDepth];
  clt_pkg::ptr_t   wp_q, rp_q;
  clt_pkg::cnt_t   cnt_q;

  logic            push, pop;
  logic [7:0]      ch, cur_idx;
  logic [6:0]      cap_lim;
  logic            keep_ok, keep_first, is_sep, is_quote, close_hit;

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tok_q <= clt_pkg::MaxTokensReset;
      cap_q     <= clt_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      unique case (clt_pkg::reg_idx_e'(cfg_idx_i))
        clt_pkg::REG_MAX_TOKENS:     max_tok_q <= cfg_wdata_i;
        clt_pkg::REG_TOKEN_CAPACITY: cap_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ch         = in_data_i.char_code;
    cur_idx    = tok_q - 8'd1;
    cap_lim    = (cap_q > clt_pkg::CapArray) ? clt_pkg::CapArray : cap_q;
    keep_ok    = (cap_lim != 7'd0) && ({1'b0, chars_q} < (cap_lim - 7'd1));
    keep_first = cap_lim > 7'd1;
    is_sep     = (ch == clt_pkg::CharSpace) || (ch == clt_pkg::CharTab);
    is_quote   = (ch == clt_pkg::CharDquote) || (ch == clt_pkg::CharSquote);
    close_hit  = qs_q ? (ch == clt_pkg::CharSquote) : (ch == clt_pkg::CharDquote);

    mode_d  = mode_q;
    qs_d    = qs_q;
    esc_d   = esc_q;
    chars_d = chars_q;
    tok_d   = tok_q;
    n_res   = 2'd0;
    for (int i = 0; i < clt_pkg::MaxResults; i++) begin
      res[i] = '0;
    end

    if (in_data_i.end_of_line) begin
      if (mode_q != clt_pkg::MODE_IDLE) begin
        if (esc_q && keep_ok) begin
          res[n_res].kind        = clt_pkg::KIND_CHAR;
          res[n_res].out_char    = clt_pkg::CharBackslash;
          res[n_res].token_index = cur_idx;
          n_res = n_res + 2'd1;
        end
        res[n_res].kind        = clt_pkg::KIND_TOKEN_END;
        res[n_res].token_index = cur_idx;
        n_res = n_res + 2'd1;
      end
      res[n_res].kind        = clt_pkg::KIND_LINE_DONE;
      res[n_res].token_count = tok_q;
      n_res = n_res + 2'd1;
      mode_d  = clt_pkg::MODE_IDLE;
      qs_d    = 1'b0;
      esc_d   = 1'b0;
      chars_d = 6'd0;
      tok_d   = 8'd0;
    end else if (mode_q == clt_pkg::MODE_IDLE) begin
      if (!is_sep && (tok_q < max_tok_q)) begin
        tok_d   = tok_q + 8'd1;
        chars_d = 6'd0;
        esc_d   = 1'b0;
        if (is_quote) begin
          mode_d = clt_pkg::MODE_QUOTED;
          qs_d   = (ch == clt_pkg::CharSquote);
        end else if (ch == clt_pkg::CharBackslash) begin
          mode_d = clt_pkg::MODE_PLAIN;
          esc_d  = 1'b1;
        end else begin
          mode_d = clt_pkg::MODE_PLAIN;
          if (keep_first) begin
            res[0].kind        = clt_pkg::KIND_CHAR;
            res[0].out_char    = ch;
            res[0].token_index = tok_q;
            n_res   = 2'd1;
            chars_d = 6'd1;
          end
        end
      end
    end else begin
      priority if (esc_q || !((ch == clt_pkg::CharBackslash) ||
                   (mode_q == clt_pkg::MODE_QUOTED && close_hit) ||
                   (mode_q == clt_pkg::MODE_PLAIN && is_sep))) begin
        esc_d = 1'b0;
        if (keep_ok) begin
          res[0].kind        = clt_pkg::KIND_CHAR;
          res[0].out_char    = ch;
          res[0].token_index = cur_idx;
          n_res   = 2'd1;
          chars_d = chars_q + 6'd1;
        end
      end else if (ch == clt_pkg::CharBackslash) begin
        esc_d = 1'b1;
      end else begin
        res[0].kind        = clt_pkg::KIND_TOKEN_END;
        res[0].token_index = cur_idx;
        n_res   = 2'd1;
        mode_d  = clt_pkg::MODE_IDLE;
        qs_d    = 1'b0;
        esc_d   = 1'b0;
        chars_d = 6'd0;
      end
    end

    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= clt_pkg::MODE_IDLE;
      qs_q    <= 1'b0;
      esc_q   <= 1'b0;
      chars_q <= 6'd0;
      tok_q   <= 8'd0;
    end else if (push) begin
      mode_q  <= mode_d;
      qs_q    <= qs_d;
      esc_q   <= esc_d;
      chars_q <= chars_d;
      tok_q   <= tok_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int i = 0; i < clt_pkg::MaxResults; i++) begin
        if (i < int'(n_res)) begin
          mem_q[wp_q + clt_pkg::ptr_t'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + clt_pkg::ptr_t'(n_res);
      end
      if (pop) begin
        rp_q <= rp_q + clt_pkg::ptr_t'(1);
      end
      cnt_q <= cnt_q + (push ? clt_pkg::cnt_t'(n_res) : clt_pkg::cnt_t'(0))
                     - (pop ? clt_pkg::cnt_t'(1) : clt_pkg::cnt_t'(0));
    end
  end

  assign in_stall_o  = cnt_q > clt_pkg::StallLevel;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rp_q];

endmodule

`default_nettype wire

FILE: hw/rtl/clt_checker.sv
// Port checker for the command line tokenizer, bound to the top level.
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module clt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire clt_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire clt_pkg::out_item_t out_data_o
);

  logic eol_take, out_held;
  logic done_seen, end_seen, char_seen;
  logic done_ok, end_ok;

  assign eol_take  = in_valid_i && !in_stall_o && in_data_i.end_of_line;
  assign out_held  = out_valid_o && out_stall_i;
  assign done_seen = out_valid_o && (out_data_o.kind == clt_pkg::KIND_LINE_DONE);
  assign end_seen  = out_valid_o && (out_data_o.kind == clt_pkg::KIND_TOKEN_END);
  assign char_seen = out_valid_o && (out_data_o.kind == clt_pkg::KIND_CHAR);
  assign done_ok   = out_data_o.last && (out_data_o.token_index == 8'd0) &&
                     (out_data_o.out_char == 8'd0);
  assign end_ok    = (out_data_o.out_char == 8'd0) && (out_data_o.token_count == 8'd0);

  `CLT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o), "item lost")
  `CLT_ASSERT(a_done_fields, clk_i, rst_ni, !done_seen || done_ok, "line finished item malformed")
  `CLT_ASSERT(a_end_fields, clk_i, rst_ni, !end_seen || end_ok, "token end item carries data")
  `CLT_ASSERT(a_char_fields, clk_i, rst_ni, !char_seen || (out_data_o.token_count == 8'd0), "count")
  `CLT_ASSERT_NEXT(a_eol_result, clk_i, rst_ni, eol_take, out_valid_o, "line end gave no item")

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

`default_nettype wire

FILE: tb/command_line_tokenizer_test.sv
// Self-checking testbench of the command line tokenizer: directed and random lines vs. a predictor.
`timescale 1ns / 100ps

module command_line_tokenizer_test;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  clt_pkg::in_item_t   in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  clt_pkg::out_item_t  out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_idx_i   = 1'b0;
  logic [7:0]          cfg_wdata_i = 8'd0;

  command_line_tokenizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  clt_pkg::out_item_t pending_results[$];
  clt_pkg::out_item_t want_item;
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          quiet_cycles   = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          hold_requests  = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;

  logic [7:0]      cur_max_tokens = clt_pkg::MaxTokensReset;
  logic [6:0]      cur_capacity   = clt_pkg::CapacityReset;
  clt_pkg::mode_e  scan_state     = clt_pkg::MODE_IDLE;
  logic            quote_single   = 1'b0;
  logic            escape_wait    = 1'b0;
  int              kept_count     = 0;
  logic [7:0]      tokens_begun   = 8'd0;

  function automatic void add_result(clt_pkg::kind_e k, logic [7:0] ch, logic [7:0] idx,
                                     logic [7:0] cnt);
    clt_pkg::out_item_t r;
    r.kind        = k;
    r.out_char    = ch;
    r.token_index = idx;
    r.token_count = cnt;
    r.last        = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void keep_char(logic [7:0] ch);
    int cap;
    cap = (cur_capacity > clt_pkg::CapArray) ? int'(clt_pkg::CapArray) : int'(cur_capacity);
    if (cap != 0 && kept_count < cap - 1) begin
      add_result(clt_pkg::KIND_CHAR, ch, tokens_begun - 8'd1, 8'd0);
      kept_count++;
    end
  endfunction

  function automatic void close_token();
    add_result(clt_pkg::KIND_TOKEN_END, 8'd0, tokens_begun - 8'd1, 8'd0);
    scan_state   = clt_pkg::MODE_IDLE;
    quote_single = 1'b0;
    escape_wait  = 1'b0;
    kept_count   = 0;
  endfunction

  function automatic void tokenize_item(clt_pkg::in_item_t it);
    int         n0;
    logic [7:0] ch;
    n0 = pending_results.size();
    ch = it.char_code;
    if (it.end_of_line) begin
      if (scan_state != clt_pkg::MODE_IDLE) begin
        if (escape_wait) keep_char(clt_pkg::CharBackslash);
        close_token();
      end
      add_result(clt_pkg::KIND_LINE_DONE, 8'd0, 8'd0, tokens_begun);
      scan_state   = clt_pkg::MODE_IDLE;
      quote_single = 1'b0;
      escape_wait  = 1'b0;
      kept_count   = 0;
      tokens_begun = 8'd0;
    end else if (scan_state == clt_pkg::MODE_IDLE) begin
      if (ch != clt_pkg::CharSpace && ch != clt_pkg::CharTab &&
          tokens_begun < cur_max_tokens) begin
        tokens_begun = tokens_begun + 8'd1;
        kept_count   = 0;
        escape_wait  = 1'b0;
        if (ch == clt_pkg::CharDquote || ch == clt_pkg::CharSquote) begin
          scan_state   = clt_pkg::MODE_QUOTED;
          quote_single = (ch == clt_pkg::CharSquote);
        end else if (ch == clt_pkg::CharBackslash) begin
          scan_state  = clt_pkg::MODE_PLAIN;
          escape_wait = 1'b1;
        end else begin
          scan_state = clt_pkg::MODE_PLAIN;
          keep_char(ch);
        end
      end
    end else if (escape_wait) begin
      escape_wait = 1'b0;
      keep_char(ch);
    end else if (ch == clt_pkg::CharBackslash) begin
      escape_wait = 1'b1;
    end else if (scan_state == clt_pkg::MODE_QUOTED &&
                 ch == (quote_single ? clt_pkg::CharSquote : clt_pkg::CharDquote)) begin
      close_token();
    end else if (scan_state == clt_pkg::MODE_PLAIN &&
                 (ch == clt_pkg::CharSpace || ch == clt_pkg::CharTab)) begin
      close_token();
    end else begin
      keep_char(ch);
    end
    if (pending_results.size() > n0) pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want_item = pending_results.pop_front();
          check_field("kind", 8'(out_data_o.kind), 8'(want_item.kind));
          check_field("out_char", out_data_o.out_char, want_item.out_char);
          check_field("token_index", out_data_o.token_index, want_item.token_index);
          check_field("token_count", out_data_o.token_count, want_item.token_count);
          check_field("last", 8'(out_data_o.last), 8'(want_item.last));
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(clt_pkg::in_item_t it);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    tokenize_item(it);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] ch);
    clt_pkg::in_item_t it;
    it.char_code   = ch;
    it.end_of_line = 1'b0;
    send_item(it);
  endtask

  task automatic send_eol();
    clt_pkg::in_item_t it;
    it.char_code   = 8'($urandom_range(255));
    it.end_of_line = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(clt_pkg::reg_idx_e idx, logic [7:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == clt_pkg::REG_MAX_TOKENS) begin
      cur_max_tokens = value;
    end else begin
      cur_capacity = value[6:0];
    end
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(9))
      0: return clt_pkg::CharSpace;
      1: return clt_pkg::CharTab;
      2: return clt_pkg::CharDquote;
      3: return clt_pkg::CharSquote;
      4: return clt_pkg::CharBackslash;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == clt_pkg::CharSpace || c == clt_pkg::CharTab ||
               c == clt_pkg::CharDquote || c == clt_pkg::CharSquote ||
               c == clt_pkg::CharBackslash);
    return c;
  endfunction

  task automatic send_body_char(logic quoted, logic [7:0] other_quote);
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      send_char(clt_pkg::CharBackslash);
      send_char(noise_char());
    end else if (pick == 1) begin
      send_char(other_quote);
    end else if (pick == 2 && quoted) begin
      send_char($urandom_range(1) ? clt_pkg::CharSpace : clt_pkg::CharTab);
    end else begin
      send_char(word_char());
    end
  endtask

  task automatic send_quoted(logic [7:0] q, int len);
    send_char(q);
    repeat (len) begin
      send_body_char(1'b1, (q == clt_pkg::CharDquote) ? clt_pkg::CharSquote
                                                      : clt_pkg::CharDquote);
    end
    if ($urandom_range(9) != 0) send_char(q);
  endtask

  task automatic send_token();
    int len;
    len = $urandom_range(0, 7);
    if ($urandom_range(19) == 0) len = $urandom_range(60, 70);
    case ($urandom_range(3))
      0: begin
        if ($urandom_range(7) == 0) begin
          send_char(clt_pkg::CharBackslash);
          send_char(noise_char());
        end else begin
          send_char(word_char());
        end
        repeat (len) send_body_char(1'b0, clt_pkg::CharSquote);
      end
      1: send_quoted(clt_pkg::CharDquote, len);
      2: send_quoted(clt_pkg::CharSquote, len);
      default: begin
        send_quoted(clt_pkg::CharDquote, len);
        send_quoted(clt_pkg::CharSquote, 2);
      end
    endcase
  endtask

  task automatic send_random_line();
    int n_tok;
    if ($urandom_range(99) < 80) begin
      n_tok = $urandom_range(0, 5);
      for (int t = 0; t < n_tok; t++) begin
        if (t > 0 || $urandom_range(1)) begin
          repeat ($urandom_range(1, 2)) begin
            send_char($urandom_range(1) ? clt_pkg::CharSpace : clt_pkg::CharTab);
          end
        end
        send_token();
      end
      if ($urandom_range(9) == 0) send_char(clt_pkg::CharBackslash);
    end else begin
      repeat ($urandom_range(12)) send_char(noise_char());
    end
    send_eol();
  endtask

  task automatic pick_config();
    logic [7:0] mt;
    logic [7:0] cp;
    case ($urandom_range(5))
      0: mt = 8'd0;
      1: mt = 8'd255;
      2: mt = 8'd1;
      default: mt = 8'($urandom_range(2, 6));
    endcase
    case ($urandom_range(6))
      0: cp = 8'd0;
      1: cp = 8'd1;
      2: cp = 8'($urandom_range(65, 255));
      3: cp = 8'd64;
      default: cp = 8'($urandom_range(2, 8));
    endcase
    write_reg(clt_pkg::REG_MAX_TOKENS, mt);
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, cp);
  endtask

  task automatic test_directed_lines();
    send_eol();
    send_text("\t\"a\\\" b\"'c'\"\"");
    send_char(8'h00);
    send_text("\\ q\"\\");
    send_eol();
    send_text("'x");
    send_eol();
  endtask

  task automatic test_config_extremes();
    write_reg(clt_pkg::REG_MAX_TOKENS, 8'd2);
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd3);
    send_text("ab cde f");
    send_eol();
    write_reg(clt_pkg::REG_MAX_TOKENS, 8'd0);
    send_text("a b");
    send_eol();
    write_reg(clt_pkg::REG_MAX_TOKENS, 8'd255);
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd0);
    send_text("ab \"c\"");
    send_eol();
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd127);
    repeat (70) send_char(word_char());
    send_eol();
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd64);
    send_char(clt_pkg::CharDquote);
    repeat (66) send_char(word_char());
    send_eol();
  endtask

  task automatic test_many_tokens();
    write_reg(clt_pkg::REG_MAX_TOKENS, 8'd20);
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd2);
    repeat (24) begin
      send_char(word_char());
      send_char(clt_pkg::CharSpace);
    end
    send_eol();
  endtask

  task automatic test_random_lines(int target);
    int start;
    int lines;
    start = items_sent;
    lines = 0;
    while (items_sent - start < target) begin
      if (lines % 6 == 0) pick_config();
      send_random_line();
      lines++;
    end
  endtask

  task automatic test_backpressure();
    write_reg(clt_pkg::REG_MAX_TOKENS, 8'd16);
    write_reg(clt_pkg::REG_TOKEN_CAPACITY, 8'd64);
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
    repeat (4) send_random_line();
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_config_extremes();
    test_random_lines(35);
    send_idle_pct = 64;
    recv_idle_pct = 16;
    test_random_lines(35);
    test_many_tokens();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(35);
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
